FILE: hw/rtl/trapezoidal_speed_profile_core_macros.svh
// Assertion macros shared by the speed profile RTL.
// Used by tsp_divider and the top level; needs no other file.
`ifndef TRAPEZOIDAL_SPEED_PROFILE_CORE_MACROS_SVH
`define TRAPEZOIDAL_SPEED_PROFILE_CORE_MACROS_SVH

// condition implies consequence on the next edge
`define TSP_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// condition implies consequence on the same edge
`define TSP_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tsp_pkg.sv
// Types and constants for the trapezoidal speed profile block.
// No dependencies.
package tsp_pkg;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CFG_W = 24;
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_RATE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DECEL_RATE = 2'd2;
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam logic [VAL_W-1:0] SAT32 = '1;

    typedef struct packed {
        logic                start;
        logic [2*VAL_W-1:0]  num;
        logic [VAL_W-1:0]    den;
    } div_req_t;
endpackage

FILE: hw/rtl/tsp_if.sv
// Valid/ready channel interfaces for the speed profile block.
// Depends on tsp_pkg.
interface tsp_in_if;
    import tsp_pkg::*;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [VAL_W-1:0]  move_length;
    modport source (output valid, operation, move_length, input ready);
    modport sink   (input valid, operation, move_length, output ready);
endinterface

interface tsp_out_if;
    import tsp_pkg::*;
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  step_distance;
    logic              final_step;
    modport source (output valid, step_distance, final_step, input ready);
    modport sink   (input valid, step_distance, final_step, output ready);
endinterface

interface tsp_cfg_if;
    import tsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tsp_divider.sv
// Bit-serial restoring divider: 64-bit numerator by 32-bit denominator,
// one quotient bit per cycle. Depends on tsp_pkg and the macro header.
`include "trapezoidal_speed_profile_core_macros.svh"
module tsp_divider
    import tsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [2*VAL_W-1:0]   quot
);
    localparam int unsigned CNT_W = $clog2(2*VAL_W+1);
    logic [2*VAL_W-1:0] q_reg, q_next;
    logic [VAL_W:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [VAL_W:0]     trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[VAL_W-1:0], q_reg[2*VAL_W-1]};
        if (req.start)
        begin
            q_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = CNT_W'(2*VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[2*VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[2*VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // zero denominator yields all ones, as a saturated quotient
    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_next;

    `TSP_ASSERT_NEXT(a_div_count, clk, rst_n, busy_reg && !req.start && cnt_reg != CNT_W'(1), busy_reg, "divider stopped early")
    `TSP_ASSERT_NOW(a_div_cnt_nz, clk, rst_n, busy_reg, cnt_reg != '0, "divider count empty while busy")
    `TSP_ASSERT_NEXT(a_div_start, clk, rst_n, req.start, busy_reg && cnt_reg == CNT_W'(2*VAL_W), "divider did not load")
endmodule

FILE: hw/rtl/tsp_sqrt.sv
// Bit-serial integer square root of a 64-bit value, one result bit per
// cycle. Depends on tsp_pkg.
module tsp_sqrt
    import tsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*VAL_W-1:0]   radicand,
    output logic                 done,
    output logic [VAL_W-1:0]     root
);
    localparam int unsigned CNT_W = $clog2(VAL_W+1);
    logic [2*VAL_W-1:0] v_reg, v_next;
    logic [VAL_W+1:0]   rem_reg, rem_next;
    logic [VAL_W-1:0]   r_reg, r_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [VAL_W+1:0]   trial, sub;

    always_comb
    begin
        v_next = v_reg;
        rem_next = rem_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[VAL_W-1:0], v_reg[2*VAL_W-1:2*VAL_W-2]};
        sub = {r_reg, 2'b01};
        if (start)
        begin
            v_next = radicand;
            rem_next = '0;
            r_next = '0;
            cnt_next = CNT_W'(VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next = {v_reg[2*VAL_W-3:0], 2'b00};
            if (trial >= sub)
            begin
                rem_next = trial - sub;
                r_next = {r_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                r_next = {r_reg[VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        rem_reg <= rem_next;
        r_reg <= r_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign root = r_next;
endmodule

FILE: hw/rtl/tsp_mul.sv
// Shift-add multiplier, 32 x 32 to 64 bits, one multiplier bit per cycle.
// Depends on tsp_pkg.
module tsp_mul
    import tsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [VAL_W-1:0]     a,
    input  logic [VAL_W-1:0]     b,
    output logic                 done,
    output logic [2*VAL_W-1:0]   prod
);
    localparam int unsigned CNT_W = $clog2(VAL_W+1);
    logic [2*VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [VAL_W:0]     hi_sum;

    always_comb
    begin
        acc_next = acc_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        hi_sum = {1'b0, acc_reg[2*VAL_W-1:VAL_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            acc_next = '0;
            a_next = a;
            b_next = b;
            cnt_next = CNT_W'(VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {hi_sum, acc_reg[VAL_W-1:1]};
            b_next = {1'b0, b_reg[VAL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign prod = acc_next;
endmodule

FILE: hw/rtl/trapezoidal_speed_profile_core.sv
// Trapezoidal speed profile generator, top level.
// Start transactions are handled in S_IDLE. A tick chains bit-serial multiply, divide and
// root units: the result is loaded in S_FIN, which holds while the previous step still
// waits in the result register, and the next transaction is taken once S_WAIT has
// returned to S_IDLE.
// Reset (rst_n low, async) clears the move state and loads register defaults.
`include "trapezoidal_speed_profile_core_macros.svh"
module trapezoidal_speed_profile_core
    import tsp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    tsp_in_if.sink      in_ch,
    tsp_out_if.source   out_ch,
    tsp_cfg_if.sink     cfg
);
    localparam int unsigned W2 = 2*VAL_W;

    // sequencer states
    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_BEGIN  = 6'd1;
    localparam logic [5:0] S_PLAN0  = 6'd2;
    localparam logic [5:0] S_RD_Q   = 6'd3;   // q = (t<<F)/r
    localparam logic [5:0] S_RD_M   = 6'd4;   // t*q
    localparam logic [5:0] S_RD_END = 6'd5;
    localparam logic [5:0] S_PLAN1  = 6'd6;
    localparam logic [5:0] S_G_M    = 6'd7;   // accel*decel
    localparam logic [5:0] S_G_D    = 6'd8;   // /(accel+decel)
    localparam logic [5:0] S_G_SQ   = 6'd9;   // g*(g+2d), 34-bit factor
    localparam logic [5:0] S_G_SQ2  = 6'd10;
    localparam logic [5:0] S_RT     = 6'd11;
    localparam logic [5:0] S_RT_END = 6'd12;
    localparam logic [5:0] S_UPD    = 6'd13;
    localparam logic [5:0] S_CR_M   = 6'd14;  // decel*p2
    localparam logic [5:0] S_CR_D   = 6'd15;
    localparam logic [5:0] S_AC_M1  = 6'd16;  // peak*p1
    localparam logic [5:0] S_AC_D1  = 6'd17;  // /avg
    localparam logic [5:0] S_AC_M2  = 6'd18;  // avg*p1
    localparam logic [5:0] S_AC_D2  = 6'd19;
    localparam logic [5:0] S_AC_M3  = 6'd20;  // peak*p2
    localparam logic [5:0] S_AC_D3  = 6'd21;
    localparam logic [5:0] S_AC_M4  = 6'd22;  // decel*p2
    localparam logic [5:0] S_AC_D4  = 6'd23;
    localparam logic [5:0] S_FIN    = 6'd24;
    localparam logic [5:0] S_WAIT   = 6'd25;

    // ramp-distance return points
    localparam logic [1:0] RD_AD = 2'd0;
    localparam logic [1:0] RD_DD = 2'd1;
    localparam logic [1:0] RD_PK = 2'd2;

    logic [CFG_W-1:0] max_speed_reg, accel_rate_reg, decel_rate_reg;
    logic [VAL_W-1:0] dist_reg, speed_reg, peak_reg, queued_reg, brake_reg;
    logic             moving_reg;
    logic [5:0]       state_reg;
    logic [1:0]       rd_sel_reg;
    logic [VAL_W-1:0] rd_t_reg, rd_r_reg, rd_q_reg, ad_reg, dd_reg;
    logic [W2-1:0]    t0_reg, t1_reg;
    logic [VAL_W-1:0] p1_reg, p2_reg, avg_reg, old_reg;
    logic [VAL_W-1:0] out_step_reg;
    logic             out_final_reg, out_valid_reg;

    // unit handshakes
    div_req_t         div_req;
    logic             div_done, mul_start, mul_done, sq_start, sq_done;
    logic [W2-1:0]    div_q, mul_p, sq_in, g_q;
    logic [VAL_W-1:0] mul_a, mul_b, sq_root;
    logic             unit_started_reg;

    tsp_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done),
        .quot(div_q));
    tsp_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_p));
    tsp_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
        .done(sq_done), .root(sq_root));

    function automatic logic [VAL_W-1:0] sat(input logic [W2-1:0] v);
        return (v[W2-1:VAL_W] != '0) ? SAT32 : v[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] subz(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    logic [VAL_W-1:0] max_w, acc_w, dec_w;
    assign max_w = VAL_W'(max_speed_reg);
    assign acc_w = VAL_W'(accel_rate_reg);
    assign dec_w = VAL_W'(decel_rate_reg);

    // the result register lets a new transaction in while a step still waits
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.step_distance = out_step_reg;
    assign out_ch.final_step = out_final_reg;

    logic in_acc, unit_done, out_free;
    assign in_acc = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // operands per state; the unit starts on the first cycle of a state
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num = '0;
        div_req.den = '0;
        mul_a = '0;
        mul_b = '0;
        sq_in = t1_reg;
        unique case (state_reg)
            S_RD_Q:  begin div_req.num = W2'(rd_t_reg) << FRAC_BITS; div_req.den = rd_r_reg; end
            S_RD_M:  begin mul_a = rd_t_reg; mul_b = rd_q_reg; end
            S_G_M:   begin mul_a = acc_w; mul_b = dec_w; end
            S_G_D:   begin div_req.num = t0_reg; div_req.den = acc_w + dec_w; end
            S_G_SQ:  begin mul_a = t0_reg[VAL_W-1:0]; mul_b = t1_reg[VAL_W-1:0]; end
            S_G_SQ2: begin mul_a = t0_reg[VAL_W-1:0]; mul_b = 32'd1; end
            S_CR_M:  begin mul_a = dec_w; mul_b = p2_reg; end
            S_CR_D:  begin div_req.num = t0_reg; div_req.den = peak_reg; end
            S_AC_M1: begin mul_a = peak_reg; mul_b = p1_reg; end
            S_AC_D1: begin div_req.num = t0_reg; div_req.den = avg_reg; end
            S_AC_M2: begin mul_a = avg_reg; mul_b = p1_reg; end
            S_AC_M3: begin mul_a = peak_reg; mul_b = p2_reg; end
            S_AC_M4: begin mul_a = dec_w; mul_b = p2_reg; end
            S_AC_D2, S_AC_D3, S_AC_D4:
            begin
                div_req.num = t0_reg;
                div_req.den = p1_reg + p2_reg;
            end
            default: ;
        endcase
        div_req.start = !unit_started_reg &&
            (state_reg == S_RD_Q || state_reg == S_G_D || state_reg == S_CR_D ||
             state_reg == S_AC_D1 || state_reg == S_AC_D2 || state_reg == S_AC_D3 ||
             state_reg == S_AC_D4);
        mul_start = !unit_started_reg &&
            (state_reg == S_RD_M || state_reg == S_G_M || state_reg == S_G_SQ ||
             state_reg == S_G_SQ2 || state_reg == S_CR_M || state_reg == S_AC_M1 ||
             state_reg == S_AC_M2 || state_reg == S_AC_M3 || state_reg == S_AC_M4);
        sq_start = !unit_started_reg && (state_reg == S_RT);
    end

    assign unit_done = div_done || mul_done || sq_done;

    // both rates zero: g is taken as 0 rather than the saturated quotient
    assign g_q = (acc_w == '0 && dec_w == '0) ? '0 : div_q;

    logic [W2-1:0] rd_sum;
    logic [VAL_W-1:0] nxt_speed, cur_speed;
    logic [VAL_W:0] nxt_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= CFG_W'(655360);
            accel_rate_reg <= CFG_W'(655360);
            decel_rate_reg <= CFG_W'(655360);
            dist_reg <= '0;
            speed_reg <= '0;
            peak_reg <= '0;
            queued_reg <= '0;
            brake_reg <= '0;
            moving_reg <= 1'b0;
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            unit_started_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_MAX_SPEED:  max_speed_reg <= cfg.data;
                    REG_ACCEL_RATE: accel_rate_reg <= cfg.data;
                    REG_DECEL_RATE: decel_rate_reg <= cfg.data;
                    default: ;
                endcase
            end
            // S_FIN reloads the register itself when it takes over a freed slot
            if (out_ch.valid && out_ch.ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;
            unit_started_reg <= (div_req.start || mul_start || sq_start) ||
                (unit_started_reg && !unit_done);
            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        if (in_ch.operation == OP_START)
                        begin
                            dist_reg <= in_ch.move_length;
                            speed_reg <= '0;
                            moving_reg <= 1'b1;
                        end
                        else if (moving_reg)
                            state_reg <= S_BEGIN;
                    end
                S_BEGIN:
                begin
                    dist_reg <= subz(dist_reg, speed_reg);
                    state_reg <= (speed_reg == '0) ? S_PLAN0 : S_UPD;
                end
                S_PLAN0:
                begin
                    peak_reg <= max_w;
                    if (dist_reg < acc_w)
                    begin
                        speed_reg <= dist_reg;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        rd_t_reg <= max_w;
                        rd_r_reg <= acc_w;
                        rd_sel_reg <= RD_AD;
                        state_reg <= S_RD_Q;
                    end
                end
                S_RD_Q:
                    if (div_done)
                    begin
                        rd_q_reg <= sat(div_q);
                        state_reg <= S_RD_M;
                    end
                S_RD_M:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_RD_END;
                    end
                S_RD_END:
                begin
                    unique case (rd_sel_reg)
                        RD_AD:
                        begin
                            ad_reg <= rd_sum[VAL_W-1:0] | {VAL_W{rd_sum[W2-1:VAL_W] != '0}};
                            rd_t_reg <= max_w;
                            rd_r_reg <= dec_w;
                            rd_sel_reg <= RD_DD;
                            state_reg <= S_RD_Q;
                        end
                        RD_DD:
                        begin
                            dd_reg <= sat(rd_sum);
                            state_reg <= S_PLAN1;
                        end
                        default:
                        begin
                            brake_reg <= sat(rd_sum);
                            state_reg <= S_UPD;
                        end
                    endcase
                end
                S_PLAN1:
                    if ({1'b0, ad_reg} + {1'b0, dd_reg} > {1'b0, dist_reg})
                        state_reg <= S_G_M;
                    else
                    begin
                        brake_reg <= dd_reg;
                        state_reg <= S_UPD;
                    end
                S_G_M:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_G_D;
                    end
                S_G_D:
                    if (div_done)
                    begin
                        // g < 2^24; g+2d < 2^34: split into low word and carry
                        t0_reg <= g_q;
                        t1_reg <= g_q + (W2'(dist_reg) << 1);
                        state_reg <= S_G_SQ;
                    end
                S_G_SQ:
                    if (mul_done)
                    begin
                        p1_reg <= mul_p[VAL_W-1:0];
                        p2_reg <= mul_p[W2-1:VAL_W];
                        state_reg <= S_G_SQ2;
                    end
                S_G_SQ2:
                    if (mul_done)
                    begin
                        // add g * high bits of (g+2d) shifted by 32, one shifted add per bit
                        t1_reg <= {p2_reg, p1_reg} +
                            ((t1_reg[VAL_W] ? W2'(t0_reg[VAL_W-1:0]) : W2'(0)) << VAL_W) +
                            ((t1_reg[VAL_W+1] ? W2'(t0_reg[VAL_W-1:0]) : W2'(0))
                                << (VAL_W+1));
                        state_reg <= S_RT;
                    end
                S_RT:
                    if (sq_done)
                    begin
                        peak_reg <= subz(sq_root, t0_reg[VAL_W-1:0]);
                        rd_t_reg <= subz(sq_root, t0_reg[VAL_W-1:0]);
                        rd_r_reg <= dec_w;
                        rd_sel_reg <= RD_PK;
                        state_reg <= S_RD_Q;
                    end
                S_UPD:
                begin
                    if (dist_reg <= brake_reg)
                    begin
                        if (dist_reg < brake_reg)
                        begin
                            if (queued_reg != '0)
                            begin
                                speed_reg <= queued_reg;
                                queued_reg <= '0;
                            end
                            else if (speed_reg > dec_w)
                                speed_reg <= speed_reg - dec_w;
                        end
                        state_reg <= S_FIN;
                    end
                    else if (speed_reg == peak_reg &&
                             {1'b0, dist_reg} < {1'b0, brake_reg} + {1'b0, speed_reg})
                    begin
                        p2_reg <= subz(peak_reg, dist_reg - brake_reg);
                        state_reg <= S_CR_M;
                    end
                    else if (speed_reg < max_w)
                    begin
                        old_reg <= speed_reg;
                        speed_reg <= nxt_speed;
                        avg_reg <= nxt_raw[VAL_W:1];
                        p1_reg <= dist_reg - brake_reg;
                        if ({1'b0, dist_reg} >= {1'b0, brake_reg} + {1'b0, nxt_speed})
                            state_reg <= S_FIN;
                        else if (nxt_raw[VAL_W:1] != '0)
                            state_reg <= S_AC_M1;
                        else
                        begin
                            p2_reg <= '0;
                            state_reg <= S_AC_M2;
                        end
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_CR_M:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        if (peak_reg == '0)
                        begin
                            queued_reg <= '0;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_CR_D;
                    end
                S_CR_D:
                    if (div_done)
                    begin
                        queued_reg <= subz(peak_reg, sat(div_q));
                        state_reg <= S_FIN;
                    end
                S_AC_M1:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_AC_D1;
                    end
                S_AC_D1:
                    if (div_done)
                    begin
                        p2_reg <= (div_q < W2'(peak_reg)) ? peak_reg - div_q[VAL_W-1:0] : '0;
                        state_reg <= S_AC_M2;
                    end
                S_AC_M2:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_AC_D2;
                    end
                S_AC_D2:
                    if (div_done)
                    begin
                        t1_reg <= div_q;
                        state_reg <= S_AC_M3;
                    end
                S_AC_M3:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_AC_D3;
                    end
                S_AC_D3:
                    if (div_done)
                    begin
                        speed_reg <= sat(t1_reg + div_q);
                        state_reg <= S_AC_M4;
                    end
                S_AC_M4:
                    if (mul_done)
                    begin
                        t0_reg <= mul_p;
                        state_reg <= S_AC_D4;
                    end
                S_AC_D4:
                    if (div_done)
                    begin
                        queued_reg <= subz(peak_reg, sat(div_q));
                        state_reg <= S_FIN;
                    end
                S_FIN:
                    // hold here while the previous step still waits in the register
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (dist_reg <= speed_reg)
                        begin
                            out_step_reg <= dist_reg;
                            out_final_reg <= 1'b1;
                            dist_reg <= '0;
                            speed_reg <= '0;
                            moving_reg <= 1'b0;
                        end
                        else
                        begin
                            out_step_reg <= speed_reg;
                            out_final_reg <= 1'b0;
                        end
                        state_reg <= S_WAIT;
                    end
                S_WAIT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ramp distance from the registered product: ((t*q)>>F + t) >> 1
    assign rd_sum = ((t0_reg >> FRAC_BITS) + W2'(rd_t_reg)) >> 1;
    assign nxt_raw = {1'b0, speed_reg} + {1'b0, peak_reg};
    assign cur_speed = speed_reg + acc_w;
    assign nxt_speed = ({1'b0, speed_reg} + {1'b0, acc_w} > {1'b0, max_w}) ? max_w : cur_speed;

    `TSP_ASSERT_NOW(a_in_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready, "input taken while busy")
    `TSP_ASSERT_NEXT(a_fin_out, clk, rst_n, state_reg == S_FIN, out_valid_reg, "result lost")
    `TSP_ASSERT_NEXT(a_final_idle, clk, rst_n, state_reg == S_FIN && out_free && dist_reg <= speed_reg, !moving_reg, "move not ended")
endmodule
